// ===== hw/rtl/hpe_pkg.sv =====
// Shared types, codes and constant text for the HPACK path extractor.
package hpe_pkg;

    // One input beat: a header byte to parse or a path byte to read.
    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
        logic       last_byte;
        logic [6:0] read_index;
    } t_in;

    // One result beat: a path byte read back or an end-of-block report.
    typedef struct packed {
        logic [7:0] path_byte;
        logic [6:0] path_length;
        logic       block_done;
        logic       huffman_path_skipped;
    } t_out;

    // Values of the action field.
    localparam logic ACT_FEED = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // Kind of the literal field being parsed.
    localparam logic KIND_CAPTURE = 1'b0;
    localparam logic KIND_SKIP    = 1'b1;

    // Where the committed path comes from.
    localparam logic [1:0] SRC_SLASH = 2'd0;
    localparam logic [1:0] SRC_INDEX = 2'd1;
    localparam logic [1:0] SRC_STORE = 2'd2;

    // Static table indexes that name the path.
    localparam logic [6:0] IDX_PATH_SLASH = 7'd4;
    localparam logic [6:0] IDX_PATH_INDEX = 7'd5;

    // Lengths of the fixed strings.
    localparam logic [6:0] LEN_SLASH      = 7'd1;
    localparam logic [6:0] LEN_INDEX_PATH = 7'd11;
    localparam logic [6:0] LEN_PATH_NAME  = 7'd5;

    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    // Result queue depth.
    localparam int unsigned QDEPTH = 4;

    // Characters of the literal name ":path".
    function automatic logic [7:0] path_name_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h3A;
            3'd1:    c = 8'h70;
            3'd2:    c = 8'h61;
            3'd3:    c = 8'h74;
            3'd4:    c = 8'h68;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Characters of the static path "/index.html".
    function automatic logic [7:0] index_path_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = 8'h2F;
            4'd1:    c = 8'h69;
            4'd2:    c = 8'h6E;
            4'd3:    c = 8'h64;
            4'd4:    c = 8'h65;
            4'd5:    c = 8'h78;
            4'd6:    c = 8'h2E;
            4'd7:    c = 8'h68;
            4'd8:    c = 8'h74;
            4'd9:    c = 8'h6D;
            4'd10:   c = 8'h6C;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/hpe_result_queue.sv =====
// Small result queue that decouples the parser pipeline from the output handshake.
module hpe_result_queue (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_push,
    input  hpe_pkg::t_out                         i_push_data,
    input  logic                                  i_pop_ready,
    output logic                                  o_valid,
    output hpe_pkg::t_out                         o_data,
    output logic [$clog2(hpe_pkg::QDEPTH+1)-1:0]  o_count
);

    localparam int unsigned PW = $clog2(hpe_pkg::QDEPTH);
    localparam int unsigned CW = $clog2(hpe_pkg::QDEPTH + 1);

    hpe_pkg::t_out r_entry [hpe_pkg::QDEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          pop;

    assign pop     = i_pop_ready && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_data  = r_entry[r_rd_ptr];
    assign o_count = r_count;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            r_count <= r_count + CW'(i_push) - CW'(pop);
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ===== hw/rtl/hpack_path_extractor.sv =====
// Top level of the HPACK path extractor: byte parser, two-bank path store and result pipeline.
//
//  Channel   Direction  Handshake                Payload
//  in        input      i_in_valid / o_in_ready  i_in_data  (hpe_pkg::t_in)
//  out       output     o_out_valid / i_out_ready o_out_data (hpe_pkg::t_out)
//
// One input beat is accepted per cycle while o_in_ready is high. A result passes the read
// stage, where the path store is read synchronously, and then the result queue register
// before it leaves the pipeline. A four-entry result queue absorbs output stalls;
// the input is held off only when the queue and the read stage together are full.
// Reset is synchronous and active low; the path store needs no clearing pass.
module hpack_path_extractor #(
    parameter int unsigned PATH_DEPTH = 128
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  hpe_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output hpe_pkg::t_out o_out_data
);

    localparam int unsigned AW = $clog2(PATH_DEPTH);
    localparam int unsigned CW = $clog2(hpe_pkg::QDEPTH + 1);

    typedef enum logic [2:0] {
        PH_REP,
        PH_NAME_LEN,
        PH_NAME,
        PH_VALUE_LEN,
        PH_VALUE
    } t_phase;

    // Parser state.
    t_phase     r_phase, n_phase;
    logic       r_kind, n_kind;
    logic [6:0] r_rem, n_rem;
    logic [6:0] r_pos, n_pos;
    logic       r_match, n_match;
    logic       r_huff, n_huff;
    logic       r_at_start, n_at_start;
    logic       r_bank, n_bank;
    logic [1:0] r_src, n_src;
    logic [6:0] r_len, n_len;
    logic       r_flag, n_flag;

    // Two-bank path store.
    logic [7:0] r_store [2**(AW+1)];
    logic [7:0] r_rd_data;
    logic [AW:0] wr_addr;
    logic [AW:0] rd_addr;
    logic        wr_en;
    logic [AW+6:0] pos_ext;
    logic [AW+6:0] idx_ext;

    // Read stage registers.
    logic       r_s1_valid;
    logic       r_s1_done;
    logic       r_s1_beyond;
    logic [1:0] r_s1_src;
    logic [6:0] r_s1_idx;
    logic [6:0] r_s1_len;
    logic       r_s1_flag;

    hpe_pkg::t_out s1_result;
    logic [CW-1:0] q_count;
    logic          accept;
    logic          feed;
    logic          produce;
    logic          finish;
    t_phase        cur_phase;
    logic [7:0]    b;

    assign accept  = i_in_valid && o_in_ready;
    assign feed    = accept && (i_in_data.action == hpe_pkg::ACT_FEED);
    assign produce = accept && ((i_in_data.action == hpe_pkg::ACT_READ) ||
                                i_in_data.last_byte);
    assign b       = i_in_data.data_byte;

    // Room for the accepted beat's result is reserved across the read stage and queue.
    assign o_in_ready = ((CW+1)'(q_count) + (CW+1)'(r_s1_valid)) < (CW+1)'(hpe_pkg::QDEPTH);

    // Next parser state for a fed header byte.
    always_comb begin
        n_phase    = r_phase;
        n_kind     = r_kind;
        n_rem      = r_rem;
        n_pos      = r_pos;
        n_match    = r_match;
        n_huff     = r_huff;
        n_at_start = r_at_start;
        n_bank     = r_bank;
        n_src      = r_src;
        n_len      = r_len;
        n_flag     = r_flag;
        wr_en      = 1'b0;
        finish     = 1'b0;
        cur_phase  = r_phase;
        if (feed) begin
            // The first byte of a block restores the default path.
            if (r_at_start) begin
                n_src     = hpe_pkg::SRC_SLASH;
                n_len     = hpe_pkg::LEN_SLASH;
                n_flag    = 1'b0;
                cur_phase = PH_REP;
            end
            n_at_start = 1'b0;
            unique case (cur_phase)
                PH_REP: begin
                    if (b[7]) begin
                        if (b[6:0] == hpe_pkg::IDX_PATH_SLASH) begin
                            n_src = hpe_pkg::SRC_SLASH;
                            n_len = hpe_pkg::LEN_SLASH;
                        end else if (b[6:0] == hpe_pkg::IDX_PATH_INDEX) begin
                            n_src = hpe_pkg::SRC_INDEX;
                            n_len = hpe_pkg::LEN_INDEX_PATH;
                        end
                    end else if (b[7:6] == 2'b01) begin
                        n_kind = hpe_pkg::KIND_CAPTURE;
                        if (b[5:0] == 6'd0) begin
                            n_phase = PH_NAME_LEN;
                        end else begin
                            n_match = ({1'b0, b[5:0]} == hpe_pkg::IDX_PATH_SLASH) ||
                                      ({1'b0, b[5:0]} == hpe_pkg::IDX_PATH_INDEX);
                            n_phase = PH_VALUE_LEN;
                        end
                    end else if (b[7:4] == 4'h0) begin
                        n_kind  = hpe_pkg::KIND_SKIP;
                        n_match = 1'b0;
                        n_phase = (b[3:0] == 4'h0) ? PH_NAME_LEN : PH_VALUE_LEN;
                    end
                end
                PH_NAME_LEN: begin
                    n_rem   = b[6:0];
                    n_pos   = '0;
                    n_match = (r_kind == hpe_pkg::KIND_CAPTURE) && !b[7] &&
                              (b[6:0] == hpe_pkg::LEN_PATH_NAME);
                    n_phase = (b[6:0] != '0) ? PH_NAME : PH_VALUE_LEN;
                end
                PH_NAME: begin
                    if (r_match && ((r_pos >= hpe_pkg::LEN_PATH_NAME) ||
                                    (b != hpe_pkg::path_name_char(r_pos[2:0])))) begin
                        n_match = 1'b0;
                    end
                    n_pos = r_pos + 7'd1;
                    n_rem = r_rem - 7'd1;
                    if (n_rem == '0) begin
                        n_phase = PH_VALUE_LEN;
                    end
                end
                PH_VALUE_LEN: begin
                    n_huff = b[7];
                    n_rem  = b[6:0];
                    n_pos  = '0;
                    if (b[6:0] == '0) begin
                        finish = 1'b1;
                    end else begin
                        n_phase = PH_VALUE;
                    end
                end
                PH_VALUE: begin
                    wr_en = (r_kind == hpe_pkg::KIND_CAPTURE) && r_match && !r_huff &&
                            (32'(r_pos) < 32'(PATH_DEPTH - 1));
                    n_pos = (r_pos == 7'h7F) ? 7'h7F : (r_pos + 7'd1);
                    n_rem = r_rem - 7'd1;
                    if (n_rem == '0) begin
                        finish = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_REP;
                end
            endcase
            // A completed value under a path name commits or sets the skip flag.
            if (finish) begin
                n_phase = PH_REP;
                if ((r_kind == hpe_pkg::KIND_CAPTURE) && r_match) begin
                    if (n_huff) begin
                        n_flag = 1'b1;
                    end else begin
                        n_bank = ~r_bank;
                        n_src  = hpe_pkg::SRC_STORE;
                        n_len  = (32'(n_pos) > 32'(PATH_DEPTH - 1)) ?
                                 7'(PATH_DEPTH - 1) : n_pos;
                    end
                end
            end
            if (i_in_data.last_byte) begin
                n_at_start = 1'b1;
                n_phase    = PH_REP;
            end
        end
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_REP;
            r_kind     <= hpe_pkg::KIND_CAPTURE;
            r_rem      <= '0;
            r_pos      <= '0;
            r_match    <= 1'b0;
            r_huff     <= 1'b0;
            r_at_start <= 1'b1;
            r_bank     <= 1'b0;
            r_src      <= hpe_pkg::SRC_SLASH;
            r_len      <= hpe_pkg::LEN_SLASH;
            r_flag     <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_kind     <= n_kind;
            r_rem      <= n_rem;
            r_pos      <= n_pos;
            r_match    <= n_match;
            r_huff     <= n_huff;
            r_at_start <= n_at_start;
            r_bank     <= n_bank;
            r_src      <= n_src;
            r_len      <= n_len;
            r_flag     <= n_flag;
        end
    end

    // New values are built in the idle bank; reads come from the committed bank.
    assign pos_ext = {{AW{1'b0}}, r_pos};
    assign idx_ext = {{AW{1'b0}}, i_in_data.read_index};
    assign wr_addr = {~r_bank, pos_ext[AW-1:0]};
    assign rd_addr = {r_bank, idx_ext[AW-1:0]};

    // Path store write port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[wr_addr] <= b;
        end
    end

    // Path store read port with registered data.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_store[rd_addr];
    end

    // Read stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= produce;
        end
    end

    // Read stage payload: the state that the result reports.
    always_ff @(posedge i_clk) begin
        if (produce) begin
            r_s1_done   <= (i_in_data.action == hpe_pkg::ACT_FEED);
            r_s1_beyond <= (i_in_data.read_index >= r_len);
            r_s1_src    <= r_src;
            r_s1_idx    <= i_in_data.read_index;
            r_s1_len    <= (i_in_data.action == hpe_pkg::ACT_READ) ? r_len : n_len;
            r_s1_flag   <= (i_in_data.action == hpe_pkg::ACT_READ) ? r_flag : n_flag;
        end
    end

    // Path byte selection from the committed source.
    always_comb begin
        s1_result.path_length          = r_s1_len;
        s1_result.block_done           = r_s1_done;
        s1_result.huffman_path_skipped = r_s1_flag;
        s1_result.path_byte            = 8'h00;
        if (!r_s1_done && !r_s1_beyond) begin
            unique case (r_s1_src)
                hpe_pkg::SRC_SLASH: begin
                    s1_result.path_byte = (r_s1_idx == '0) ? hpe_pkg::CHAR_SLASH : 8'h00;
                end
                hpe_pkg::SRC_INDEX: begin
                    s1_result.path_byte = (r_s1_idx < hpe_pkg::LEN_INDEX_PATH) ?
                                          hpe_pkg::index_path_char(r_s1_idx[3:0]) : 8'h00;
                end
                hpe_pkg::SRC_STORE: begin
                    s1_result.path_byte = r_rd_data;
                end
                default: begin
                    s1_result.path_byte = 8'h00;
                end
            endcase
        end
    end

    hpe_result_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_s1_valid),
        .i_push_data (s1_result),
        .i_pop_ready (i_out_ready),
        .o_valid     (o_out_valid),
        .o_data      (o_out_data),
        .o_count     (q_count)
    );

endmodule

// ===== hw/rtl/hpe_checker.sv =====
// Port-level checks for the HPACK path extractor, bound to its top level.
module hpe_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          i_in_ready,
    input hpe_pkg::t_in  i_in_data,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input hpe_pkg::t_out i_out_data
);

    // The result channel is empty once a reset edge has passed.
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // An end-of-block report never carries a path byte.
    a_done_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_data.block_done) |-> (i_out_data.path_byte == 8'h00))
        else $error("end-of-block result with nonzero path byte");

    // A nonzero path byte can only come from a nonempty path.
    a_byte_needs_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_data.path_byte != 8'h00)) |->
        (i_out_data.path_length != 7'd0))
        else $error("path byte returned from an empty path");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled result beat changed");

    // A stalled input beat holds until the block takes it.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !i_in_ready) |=> (i_in_valid && $stable(i_in_data)))
        else $error("stalled input beat changed");

endmodule

bind hpack_path_extractor hpe_checker u_hpe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);

// ===== verif/hpe_path_checker.sv =====
// Result checker for the HPACK path extractor: predicts every result beat and compares it.
module hpe_path_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  hpe_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  hpe_pkg::t_out i_out_data,
    output int            o_fail_count,
    output int            o_outstanding,
    output int            o_compared
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        P_REPR,
        P_NAME_LEN,
        P_NAME,
        P_VAL_LEN,
        P_VAL
    } t_phase;

    localparam int unsigned     DEPTH       = 128;
    localparam logic [6:0]      LEN_MAX     = 7'(DEPTH - 1);
    localparam logic [8*5-1:0]  NAME_TEXT   = ":path";
    localparam logic [8*11-1:0] INDEX_TEXT  = "/index.html";
    localparam int              MAX_REPORTS = 10;

    // Parser state of the predicted block.
    t_phase     phase;
    logic       kind;
    logic [6:0] remain;
    logic [6:0] pos;
    logic       name_hit;
    logic       huff;
    logic       fresh;

    // Committed path and the two-bank store behind it.
    logic [7:0] store [2*DEPTH];
    logic       bank;
    logic [1:0] src;
    logic [6:0] path_len;
    logic       skipped;

    hpe_pkg::t_out expected_q[$];
    int   fails;
    int   compared;

    // Byte of the committed path at a position, zero past its end.
    function automatic logic [7:0] committed_char(input logic [6:0] idx);
        logic [7:0] c;
        c = 8'h00;
        if (idx < path_len) begin
            case (src)
                hpe_pkg::SRC_SLASH: c = (idx == 7'd0) ? 8'h2F : 8'h00;
                hpe_pkg::SRC_INDEX: if (idx < hpe_pkg::LEN_INDEX_PATH)
                    c = INDEX_TEXT[8*(10 - int'(idx)) +: 8];
                hpe_pkg::SRC_STORE: c = store[{bank, idx}];
                default:   c = 8'h00;
            endcase
        end
        return c;
    endfunction

    // A value is complete: commit it if it belongs to the path, or flag a Huffman one.
    // The position never passes the deepest entry, so the length saturates by itself.
    function automatic void close_value();
        phase = P_REPR;
        if (kind == hpe_pkg::KIND_CAPTURE && name_hit) begin
            if (huff) begin
                skipped = 1'b1;
            end else begin
                bank     = ~bank;
                src      = hpe_pkg::SRC_STORE;
                path_len = pos;
            end
        end
    endfunction

    // Advance the header parser by one byte.
    function automatic void parse_byte(input logic [7:0] b);
        case (phase)
            P_REPR: begin
                if (b[7]) begin
                    // Indexed field; only the two path entries matter.
                    if (b[6:0] == hpe_pkg::IDX_PATH_SLASH) begin
                        src      = hpe_pkg::SRC_SLASH;
                        path_len = hpe_pkg::LEN_SLASH;
                    end else if (b[6:0] == hpe_pkg::IDX_PATH_INDEX) begin
                        src      = hpe_pkg::SRC_INDEX;
                        path_len = hpe_pkg::LEN_INDEX_PATH;
                    end
                end else if (b[7:6] == 2'b01) begin
                    // Literal with incremental indexing.
                    kind = hpe_pkg::KIND_CAPTURE;
                    if (b[5:0] == 6'd0) begin
                        phase = P_NAME_LEN;
                    end else begin
                        name_hit = (b[5:0] == hpe_pkg::IDX_PATH_SLASH) ||
                                   (b[5:0] == hpe_pkg::IDX_PATH_INDEX);
                        phase    = P_VAL_LEN;
                    end
                end else if (b[7:4] == 4'h0) begin
                    // Literal without indexing is parsed and thrown away.
                    kind     = hpe_pkg::KIND_SKIP;
                    name_hit = 1'b0;
                    phase    = (b[3:0] == 4'h0) ? P_NAME_LEN : P_VAL_LEN;
                end
                // Any other leading byte is skipped on its own.
            end
            P_NAME_LEN: begin
                remain   = b[6:0];
                pos      = 7'd0;
                name_hit = (kind == hpe_pkg::KIND_CAPTURE) && !b[7] &&
                           (b[6:0] == hpe_pkg::LEN_PATH_NAME);
                phase    = (remain != 7'd0) ? P_NAME : P_VAL_LEN;
            end
            P_NAME: begin
                if (name_hit && !(pos < hpe_pkg::LEN_PATH_NAME &&
                                  b == NAME_TEXT[8*(4 - int'(pos)) +: 8]))
                    name_hit = 1'b0;
                pos    = pos + 7'd1;
                remain = remain - 7'd1;
                if (remain == 7'd0) phase = P_VAL_LEN;
            end
            P_VAL_LEN: begin
                huff   = b[7];
                remain = b[6:0];
                pos    = 7'd0;
                if (remain == 7'd0) close_value();
                else phase = P_VAL;
            end
            P_VAL: begin
                // New path bytes go to the bank that is not on display.
                if (kind == hpe_pkg::KIND_CAPTURE && name_hit && !huff && pos < LEN_MAX)
                    store[{~bank, pos}] = b;
                pos    = (pos == LEN_MAX) ? LEN_MAX : pos + 7'd1;
                remain = remain - 7'd1;
                if (remain == 7'd0) close_value();
            end
            default: phase = P_REPR;
        endcase
    endfunction

    always @(posedge i_clk) begin : watch
        hpe_pkg::t_out want;
        hpe_pkg::t_out got;
        if (!i_rst_n) begin
            phase    = P_REPR;
            kind     = hpe_pkg::KIND_CAPTURE;
            remain   = 7'd0;
            pos      = 7'd0;
            name_hit = 1'b0;
            huff     = 1'b0;
            fresh    = 1'b1;
            bank     = 1'b0;
            src      = hpe_pkg::SRC_SLASH;
            path_len = hpe_pkg::LEN_SLASH;
            skipped  = 1'b0;
            expected_q.delete();
            fails    = 0;
            compared = 0;
        end else begin
            // Predict from each accepted input beat.
            if (i_in_valid && i_in_ready) begin
                if (i_in_data.action == hpe_pkg::ACT_READ) begin
                    want = '{path_byte: committed_char(i_in_data.read_index),
                             path_length: path_len, block_done: 1'b0,
                             huffman_path_skipped: skipped};
                    expected_q.push_back(want);
                end else begin
                    // The first byte of a block starts over from "/".
                    if (fresh) begin
                        src      = hpe_pkg::SRC_SLASH;
                        path_len = hpe_pkg::LEN_SLASH;
                        skipped  = 1'b0;
                        phase    = P_REPR;
                        fresh    = 1'b0;
                    end
                    parse_byte(i_in_data.data_byte);
                    if (i_in_data.last_byte) begin
                        // A field cut off by the end of the block is dropped.
                        fresh = 1'b1;
                        phase = P_REPR;
                        want  = '{path_byte: 8'h00, path_length: path_len, block_done: 1'b1,
                                  huffman_path_skipped: skipped};
                        expected_q.push_back(want);
                    end
                end
            end

            // Compare each accepted result beat with the oldest prediction.
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (expected_q.size() == 0) begin
                    fails++;
                    if (fails <= MAX_REPORTS)
                        $display("%0t: unexpected result beat: byte %02h len %0d done %0b skip %0b",
                                 $realtime, got.path_byte, got.path_length, got.block_done,
                                 got.huffman_path_skipped);
                end else begin
                    want = expected_q.pop_front();
                    compared++;
                    if (got.path_byte !== want.path_byte ||
                        got.path_length !== want.path_length ||
                        got.block_done !== want.block_done ||
                        got.huffman_path_skipped !== want.huffman_path_skipped) begin
                        fails++;
                        if (fails <= MAX_REPORTS)
                            $display({"%0t: result mismatch: expected byte %02h len %0d done %0b",
                                      " skip %0b, got byte %02h len %0d done %0b skip %0b"},
                                     $realtime, want.path_byte, want.path_length,
                                     want.block_done, want.huffman_path_skipped,
                                     got.path_byte, got.path_length, got.block_done,
                                     got.huffman_path_skipped);
                    end
                end
            end
        end
        o_fail_count  <= fails;
        o_outstanding <= expected_q.size();
        o_compared    <= compared;
    end

endmodule

// ===== verif/tb_hpack_path_extractor.sv =====
// Testbench top for the HPACK path extractor: clock, reset, header-block stimulus and verdict.
module tb_hpack_path_extractor;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int             BEAT_TARGET   = 530;
    localparam int             SETTLE_CYCLES = 6;
    localparam logic [8*5-1:0] NAME_TEXT     = ":path";

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          in_valid  = 1'b0;
    logic          in_ready;
    hpe_pkg::t_in  in_data   = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    hpe_pkg::t_out out_data;
    logic          gaps_on   = 1'b1;

    int fail_count;
    int outstanding;
    int compared;
    int beats_sent  = 0;
    int blocks_sent = 0;
    int reads_sent  = 0;

    // Header block under construction.
    logic [7:0] blk[$];

    always #6 clk = ~clk;

    hpack_path_extractor uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    hpe_path_checker path_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_data    (out_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_compared    (compared)
    );

    // The receiver stalls now and then while gaps are enabled.
    always @(posedge clk) begin
        out_ready <= gaps_on ? ($urandom_range(99) >= 8) : 1'b1;
    end

    // Offer one beat, with random idle cycles ahead of it, and wait until it is taken.
    task automatic push_beat(input hpe_pkg::t_in beat);
        while (gaps_on && $urandom_range(99) < 8) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do @(posedge clk); while (!in_ready);
        beats_sent++;
    endtask

    task automatic read_path(input logic [6:0] idx);
        push_beat('{action: hpe_pkg::ACT_READ, data_byte: 8'($urandom),
                    last_byte: 1'($urandom), read_index: idx});
        reads_sent++;
    endtask

    // Read positions mostly near the front, where short paths live.
    function automatic logic [6:0] pick_index();
        return ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(15));
    endfunction

    // Send the built block, the last byte flagged; reads may slip in between bytes.
    task automatic send_blk(input bit mix_reads);
        foreach (blk[k]) begin
            if (mix_reads && $urandom_range(15) == 0) read_path(pick_index());
            push_beat('{action: hpe_pkg::ACT_FEED, data_byte: blk[k],
                        last_byte: 1'(k == blk.size() - 1), read_index: 7'($urandom)});
        end
        blocks_sent++;
    endtask

    // Stop sending until every predicted result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Value with a length prefix; mostly short, rarely close to the store depth.
    task automatic add_value();
        int n;
        n = ($urandom_range(39) == 0) ? $urandom_range(127, 100) : $urandom_range(12);
        blk.push_back({1'($urandom_range(7) == 0), 7'(n)});
        repeat (n) blk.push_back(8'($urandom));
    endtask

    // Literal name: ":path" plain, Huffman-flagged or damaged, or something else.
    task automatic add_name();
        int pick;
        int bad;
        int n;
        logic [7:0] c;
        pick = $urandom_range(9);
        if (pick < 7) begin
            bad = (pick == 6) ? $urandom_range(4) : -1;
            blk.push_back((pick == 5) ? 8'h85 : 8'h05);
            for (int i = 0; i < 5; i++) begin
                c = NAME_TEXT[8*(4 - i) +: 8];
                blk.push_back((i == bad) ? c ^ 8'($urandom_range(255, 1)) : c);
            end
        end else begin
            n = $urandom_range(8);
            blk.push_back({1'($urandom), 7'(n)});
            repeat (n) blk.push_back(8'($urandom));
        end
    endtask

    // One header field of a random kind, or a stray byte.
    task automatic add_field();
        int sel;
        logic [5:0] name_idx;
        logic [3:0] lead;
        sel = $urandom_range(99);
        if (sel < 15) begin
            // Indexed field, mostly one of the two path entries.
            blk.push_back({1'b1, ($urandom_range(1) != 0) ? 7'($urandom_range(5, 4))
                                                          : 7'($urandom)});
        end else if (sel < 45) begin
            // Literal with indexing and an indexed name.
            name_idx = ($urandom_range(2) != 0) ? 6'($urandom_range(5, 4))
                                                : 6'($urandom_range(63, 1));
            blk.push_back({2'b01, name_idx});
            add_value();
        end else if (sel < 70) begin
            // Literal with indexing and a spelled-out name.
            blk.push_back(8'h40);
            add_name();
            add_value();
        end else if (sel < 85) begin
            // Literal without indexing.
            lead = ($urandom_range(1) != 0) ? 4'h0 : 4'($urandom);
            blk.push_back({4'h0, lead});
            if (lead == 4'h0) add_name();
            add_value();
        end else if (sel < 93) begin
            blk.push_back(8'($urandom_range(8'h3F, 8'h10)));
        end else begin
            blk.push_back(8'($urandom));
        end
    endtask

    // Run limit in case the block hangs.
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int  cut;
        bit  paused;
        paused = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reads at reset, the "/index.html" entry, and the read extremes.
        read_path(7'd0);
        blk = {8'h85};
        send_blk(1'b0);
        read_path(7'd10);
        read_path(7'd127);
        // A path value cut off by the end of its block.
        blk = {8'h44, 8'h05, 8'h61};
        send_blk(1'b0);
        // Huffman path value, stray byte, "/" entry, unused index, then an empty value.
        blk = {8'h44, 8'h82, 8'h11, 8'h22, 8'h3F, 8'h84, 8'h83, 8'h45, 8'h00};
        send_blk(1'b0);
        // Spelled-out ":path" name with a value of extreme bytes.
        blk = {8'h40, 8'h05, 8'h3A, 8'h70, 8'h61, 8'h74, 8'h68, 8'h02, 8'hFF, 8'h00};
        send_blk(1'b0);
        read_path(7'd0);
        read_path(7'd1);
        drain_results();

        // Random blocks of well-formed fields, with noise and some truncated blocks.
        while (beats_sent < BEAT_TARGET) begin
            gaps_on <= !(beats_sent >= 150 && beats_sent < 300);
            if (!paused && beats_sent >= 250) begin
                drain_results();
                paused = 1'b1;
            end
            blk.delete();
            repeat ($urandom_range(4, 1)) add_field();
            if (blk.size() > 1 && $urandom_range(7) == 0) begin
                cut = $urandom_range(blk.size() - 1, 1);
                blk = blk[0:cut-1];
            end
            send_blk(1'b1);
            repeat ($urandom_range(2)) read_path(pick_index());
        end
        drain_results();

        $display("Run covered %0d header blocks and %0d path reads over %0d input beats.",
                 blocks_sent, reads_sent, beats_sent);
        $display("%0d result beats compared, %0d mismatches.", compared, fail_count);
        if (fail_count == 0 && outstanding == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
